// ===== src/dcpid_pkg.sv =====
`default_nettype none
package dcpid_pkg;

  localparam int GAIN_BITS          = 16;
  localparam int DRIVE_BITS         = 13;
  localparam int DRIVE_LIMIT        = 3072;
  localparam int POSITION_BITS_DEF  = 24;
  localparam int SUM_BITS_DEF       = 32;
  localparam int CFG_IDX_BITS       = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEFT_KP      = 3'd0,
    REG_LEFT_KI      = 3'd1,
    REG_LEFT_KD      = 3'd2,
    REG_RIGHT_KP     = 3'd3,
    REG_RIGHT_KI     = 3'd4,
    REG_RIGHT_KD     = 3'd5,
    REG_LEFT_TARGET  = 3'd6,
    REG_RIGHT_TARGET = 3'd7
  } cfg_reg_e;

  // pipeline control handed to each side
  typedef struct packed {
    logic adv;  // all stages move one step
    logic upd;  // a valid item leaves the input register: update loop state
  } side_ctrl_t;

endpackage
`default_nettype wire

// ===== src/dcpid_side.sv =====
`default_nettype none
module dcpid_side #(
  parameter int POSITION_BITS = dcpid_pkg::POSITION_BITS_DEF,
  parameter int SUM_BITS      = dcpid_pkg::SUM_BITS_DEF
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire dcpid_pkg::side_ctrl_t                ctrl_i,
  input  wire logic signed [dcpid_pkg::GAIN_BITS-1:0] kp_i,
  input  wire logic signed [dcpid_pkg::GAIN_BITS-1:0] ki_i,
  input  wire logic signed [dcpid_pkg::GAIN_BITS-1:0] kd_i,
  input  wire logic signed [POSITION_BITS-1:0]      target_i,
  input  wire logic signed [POSITION_BITS-1:0]      position_i,
  output logic signed [dcpid_pkg::DRIVE_BITS-1:0]   drive_o,
  output logic                                      clamped_o
);
  import dcpid_pkg::*;

  localparam int EW  = POSITION_BITS + 1;              // error
  localparam int DW  = EW + 1;                          // derivative
  localparam int AW  = ((SUM_BITS > EW) ? SUM_BITS : EW) + 1;
  localparam int PPW = GAIN_BITS + EW;
  localparam int PDW = GAIN_BITS + DW;
  localparam int PIW = GAIN_BITS + SUM_BITS;
  localparam int WW  = ((PIW > PDW) ? PIW : PDW) + 2;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic signed [WW-1:0]       LIM_HI  = WW'(DRIVE_LIMIT);
  localparam logic signed [WW-1:0]       LIM_LO  = -LIM_HI;

  // loop state
  logic signed [EW-1:0]       last_err_q;
  logic signed [SUM_BITS-1:0] sum_q;

  // stage 1
  logic signed [EW-1:0]       err_d, err_q;
  logic signed [DW-1:0]       deriv_d, deriv_q;
  logic signed [AW-1:0]       sum_wide;
  logic signed [SUM_BITS-1:0] sum_d, sumv_q;

  // stage 2
  logic signed [PPW-1:0]      pp_d, pp_q;
  logic signed [PDW-1:0]      pd_d, pd_q;
  logic signed [PIW-1:0]      pi_d, pi_q;

  // stage 3
  logic signed [WW-1:0]         power;
  logic signed [DRIVE_BITS-1:0] drive_d;
  logic                         clamped_d;

  always_comb begin
    err_d    = EW'(target_i) - EW'(position_i);
    deriv_d  = DW'(err_d) - DW'(last_err_q);
    sum_wide = AW'(sum_q) + AW'(err_d);
    if (sum_wide > AW'(SUM_MAX)) begin
      sum_d = SUM_MAX;
    end else if (sum_wide < AW'(SUM_MIN)) begin
      sum_d = SUM_MIN;
    end else begin
      sum_d = SUM_BITS'(sum_wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      sum_q      <= '0;
    end else if (ctrl_i.upd) begin
      last_err_q <= err_d;
      sum_q      <= sum_d;
    end
  end

  assign pp_d = PPW'(kp_i) * PPW'(err_q);
  assign pd_d = PDW'(kd_i) * PDW'(deriv_q);
  assign pi_d = PIW'(ki_i) * PIW'(sumv_q);

  always_comb begin
    power = WW'(pp_q) + WW'(pd_q) + WW'(pi_q);
    if (power > LIM_HI) begin
      drive_d   = DRIVE_BITS'(LIM_HI);
      clamped_d = 1'b1;
    end else if (power < LIM_LO) begin
      drive_d   = DRIVE_BITS'(LIM_LO);
      clamped_d = 1'b1;
    end else begin
      drive_d   = DRIVE_BITS'(power);
      clamped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      err_q     <= err_d;
      deriv_q   <= deriv_d;
      sumv_q    <= sum_d;
      pp_q      <= pp_d;
      pd_q      <= pd_d;
      pi_q      <= pi_d;
      drive_o   <= drive_d;
      clamped_o <= clamped_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/dual_channel_pid_position_controller.sv =====
`default_nettype none
// Two PID position loops (left and right) in a four-stage pipeline:
// input register, error/integral stage, multiply stage, sum-and-clamp output register.
// Throughput: one item per cycle; the whole pipe holds while a result is stalled.
// Reset: gains, targets, last error and integral all clear to zero; pipe empties.
module dual_channel_pid_position_controller #(
  parameter int POSITION_BITS = dcpid_pkg::POSITION_BITS_DEF,
  parameter int SUM_BITS      = dcpid_pkg::SUM_BITS_DEF,
  parameter int CFG_BITS      = (POSITION_BITS > dcpid_pkg::GAIN_BITS) ?
                                POSITION_BITS : dcpid_pkg::GAIN_BITS
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          cfg_we_i,
  input  wire logic [dcpid_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  wire logic [CFG_BITS-1:0]                     cfg_data_i,
  input  wire                                          in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [POSITION_BITS-1:0]         left_position_i,
  input  wire logic signed [POSITION_BITS-1:0]         right_position_i,
  output logic                                         out_valid_o,
  input  wire                                          out_stall_i,
  output logic signed [dcpid_pkg::DRIVE_BITS-1:0]      left_drive_o,
  output logic signed [dcpid_pkg::DRIVE_BITS-1:0]      right_drive_o,
  output logic                                         left_clamped_o,
  output logic                                         right_clamped_o
);
  import dcpid_pkg::*;

  logic signed [GAIN_BITS-1:0]     left_kp_q, left_ki_q, left_kd_q;
  logic signed [GAIN_BITS-1:0]     right_kp_q, right_ki_q, right_kd_q;
  logic signed [POSITION_BITS-1:0] left_target_q, right_target_q;

  logic signed [POSITION_BITS-1:0] left_pos_q, right_pos_q;
  logic                            v0_q, v1_q, v2_q, out_valid_q;
  logic                            adv;
  side_ctrl_t                      ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_kp_q      <= '0;
      left_ki_q      <= '0;
      left_kd_q      <= '0;
      right_kp_q     <= '0;
      right_ki_q     <= '0;
      right_kd_q     <= '0;
      left_target_q  <= '0;
      right_target_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LEFT_KP:      left_kp_q      <= cfg_data_i[GAIN_BITS-1:0];
        REG_LEFT_KI:      left_ki_q      <= cfg_data_i[GAIN_BITS-1:0];
        REG_LEFT_KD:      left_kd_q      <= cfg_data_i[GAIN_BITS-1:0];
        REG_RIGHT_KP:     right_kp_q     <= cfg_data_i[GAIN_BITS-1:0];
        REG_RIGHT_KI:     right_ki_q     <= cfg_data_i[GAIN_BITS-1:0];
        REG_RIGHT_KD:     right_kd_q     <= cfg_data_i[GAIN_BITS-1:0];
        REG_LEFT_TARGET:  left_target_q  <= cfg_data_i[POSITION_BITS-1:0];
        REG_RIGHT_TARGET: right_target_q <= cfg_data_i[POSITION_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign ctrl.adv   = adv;
  assign ctrl.upd   = adv && v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v0_q        <= in_valid_i;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      left_pos_q  <= left_position_i;
      right_pos_q <= right_position_i;
    end
  end

  assign out_valid_o = out_valid_q;

  dcpid_side #(
    .POSITION_BITS (POSITION_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .kp_i       (left_kp_q),
    .ki_i       (left_ki_q),
    .kd_i       (left_kd_q),
    .target_i   (left_target_q),
    .position_i (left_pos_q),
    .drive_o    (left_drive_o),
    .clamped_o  (left_clamped_o)
  );

  dcpid_side #(
    .POSITION_BITS (POSITION_BITS),
    .SUM_BITS      (SUM_BITS)
  ) u_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .kp_i       (right_kp_q),
    .ki_i       (right_ki_q),
    .kd_i       (right_kd_q),
    .target_i   (right_target_q),
    .position_i (right_pos_q),
    .drive_o    (right_drive_o),
    .clamped_o  (right_clamped_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
  import dcpid_pkg::*;

  localparam int PB             = POSITION_BITS_DEF;
  localparam int CB             = (PB > GAIN_BITS) ? PB : GAIN_BITS;
  localparam int PIPE_DEPTH     = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LEFT           = 0;
  localparam int RIGHT          = 1;

  localparam logic [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
  localparam logic [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = {1'b0, {(GAIN_BITS-1){1'b1}}};
  localparam logic [GAIN_BITS-1:0] GAIN_MIN = {1'b1, {(GAIN_BITS-1){1'b0}}};
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1 << 8);  // 256 in Q16.0 (integer gain, no fraction bits)
  localparam logic [CB-GAIN_BITS-1:0] JUNK  = '1;      // bits above a gain field
  localparam longint SUM_HI = (64'sd1 <<< (SUM_BITS_DEF - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  logic                        clk_i            = 1'b0;
  logic                        rst_ni           = 1'b0;
  logic                        cfg_we_i         = 1'b0;
  logic [CFG_IDX_BITS-1:0]     cfg_idx_i        = '0;
  logic [CB-1:0]               cfg_data_i       = '0;
  logic                        in_valid_i       = 1'b0;
  wire                         in_stall_o;
  logic signed [PB-1:0]        left_position_i  = '0;
  logic signed [PB-1:0]        right_position_i = '0;
  wire                         out_valid_o;
  logic                        out_stall_i      = 1'b0;
  wire signed [DRIVE_BITS-1:0] left_drive_o;
  wire signed [DRIVE_BITS-1:0] right_drive_o;
  wire                         left_clamped_o;
  wire                         right_clamped_o;

  dual_channel_pid_position_controller DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .left_position_i (left_position_i),
    .right_position_i(right_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_drive_o    (left_drive_o),
    .right_drive_o   (right_drive_o),
    .left_clamped_o  (left_clamped_o),
    .right_clamped_o (right_clamped_o)
  );

  typedef struct {
    logic signed [DRIVE_BITS-1:0] left_drive;
    logic signed [DRIVE_BITS-1:0] right_drive;
    logic                         left_clamped;
    logic                         right_clamped;
  } drive_result_t;

  // loop model: shadow registers and per-side state
  logic signed [GAIN_BITS-1:0] kp_gain [2];
  logic signed [GAIN_BITS-1:0] ki_gain [2];
  logic signed [GAIN_BITS-1:0] kd_gain [2];
  logic signed [PB-1:0]        target_pos [2];
  longint                      prev_error [2];
  longint                      error_sum [2];

  drive_result_t expected_drives[$];

  bit steady          = 1'b0;  // no gaps and no stalls while set
  int mismatches      = 0;
  int ticks_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int left_clamps     = 0;
  int right_clamps    = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 34);
  end

  function automatic void step_loop(input int s, input logic signed [PB-1:0] pos,
                                    output logic signed [DRIVE_BITS-1:0] drive,
                                    output logic clamp);
    longint err, slope, power;
    err = longint'(target_pos[s]) - longint'(pos);
    slope = err - prev_error[s];
    error_sum[s] = error_sum[s] + err;
    if (error_sum[s] > SUM_HI) error_sum[s] = SUM_HI;
    else if (error_sum[s] < SUM_LO) error_sum[s] = SUM_LO;
    power = longint'(kp_gain[s]) * err + longint'(kd_gain[s]) * slope
          + longint'(ki_gain[s]) * error_sum[s];
    prev_error[s] = err;
    clamp = 1'b1;
    if (power > DRIVE_LIMIT) power = DRIVE_LIMIT;
    else if (power < -DRIVE_LIMIT) power = -DRIVE_LIMIT;
    else clamp = 1'b0;
    drive = power[DRIVE_BITS-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
             what, got, want, results_checked);
  endtask

  always @(negedge clk_i) begin : check_drives
    drive_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drives.size() == 0) begin
        flag_mismatch("result with no tick pending", 0, 0);
      end else begin
        want = expected_drives.pop_front();
        if (left_drive_o !== want.left_drive)
          flag_mismatch("left_drive", left_drive_o, want.left_drive);
        if (right_drive_o !== want.right_drive)
          flag_mismatch("right_drive", right_drive_o, want.right_drive);
        if (left_clamped_o !== want.left_clamped)
          flag_mismatch("left_clamped", left_clamped_o, want.left_clamped);
        if (right_clamped_o !== want.right_clamped)
          flag_mismatch("right_clamped", right_clamped_o, want.right_clamped);
        results_checked++;
        if (want.left_clamped) left_clamps++;
        if (want.right_clamped) right_clamps++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the tick is taken.
  task automatic send_tick(input logic signed [PB-1:0] lp, input logic signed [PB-1:0] rp);
    drive_result_t r;
    while (!steady && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    left_position_i  <= lp;
    right_position_i <= rp;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    step_loop(LEFT, lp, r.left_drive, r.left_clamped);
    step_loop(RIGHT, rp, r.right_drive, r.right_clamped);
    expected_drives.push_back(r);
    ticks_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH * 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CB-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_LEFT_KP:      kp_gain[LEFT]     = data[GAIN_BITS-1:0];
      REG_LEFT_KI:      ki_gain[LEFT]     = data[GAIN_BITS-1:0];
      REG_LEFT_KD:      kd_gain[LEFT]     = data[GAIN_BITS-1:0];
      REG_RIGHT_KP:     kp_gain[RIGHT]    = data[GAIN_BITS-1:0];
      REG_RIGHT_KI:     ki_gain[RIGHT]    = data[GAIN_BITS-1:0];
      REG_RIGHT_KD:     kd_gain[RIGHT]    = data[GAIN_BITS-1:0];
      REG_LEFT_TARGET:  target_pos[LEFT]  = data[PB-1:0];
      REG_RIGHT_TARGET: target_pos[RIGHT] = data[PB-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_side(input int s, input logic [CB-1:0] kp, input logic [CB-1:0] ki,
                          input logic [CB-1:0] kd, input logic [CB-1:0] target);
    if (s == LEFT) begin
      write_reg(REG_LEFT_KP, kp);
      write_reg(REG_LEFT_KI, ki);
      write_reg(REG_LEFT_KD, kd);
      write_reg(REG_LEFT_TARGET, target);
    end else begin
      write_reg(REG_RIGHT_KP, kp);
      write_reg(REG_RIGHT_KI, ki);
      write_reg(REG_RIGHT_KD, kd);
      write_reg(REG_RIGHT_TARGET, target);
    end
  endtask

  // gain with random junk above bit 15
  function automatic logic [CB-1:0] rand_gain();
    logic [CB-1:0] d;
    int v;
    d = CB'($urandom);
    case ($urandom_range(0, 5))
      0: d[GAIN_BITS-1:0] = '0;
      1, 2: begin
        v = $urandom_range(0, 600);
        v = v - 300;
        d[GAIN_BITS-1:0] = v[GAIN_BITS-1:0];
      end
      3: d[GAIN_BITS-1:0] = GAIN_BITS'($urandom);
      4: d[GAIN_BITS-1:0] = GAIN_MAX;
      default: d[GAIN_BITS-1:0] = GAIN_MIN;
    endcase
    return d;
  endfunction

  function automatic logic [CB-1:0] rand_target();
    int v;
    case ($urandom_range(0, 4))
      0, 1: begin
        v = $urandom_range(0, 2000);
        v = v - 1000;
        return v[CB-1:0];
      end
      2: return CB'($urandom);
      3: return POS_MAX;
      default: return POS_MIN;
    endcase
  endfunction

  // mostly close to the target so the drive stays inside the rails
  function automatic logic signed [PB-1:0] rand_position(input logic signed [PB-1:0] aim);
    int off;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        off = $urandom_range(0, 32);
        off = off - 16;
        return aim + off[PB-1:0];
      end
      5, 6: begin
        off = $urandom_range(0, 4000);
        off = off - 2000;
        return aim + off[PB-1:0];
      end
      7, 8: return PB'($urandom);
      default: return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
    endcase
  endfunction

  // zero gains after reset: drive must be zero whatever the error
  task automatic test_reset_state();
    send_tick(POS_MAX, POS_MIN);
    send_tick(POS_MIN, POS_MAX);
    send_tick(0, 0);
    settle();
  endtask

  // an error of exactly 12 (drive at the 3072 limit) is not flagged, one step more is
  task automatic test_clamp_edges();
    set_side(LEFT, GAIN_ONE, 0, 0, 0);
    set_side(RIGHT, -GAIN_ONE, 0, 0, 100);
    send_tick(-12, 88);
    send_tick(-13, 87);
    send_tick(12, 112);
    send_tick(13, 113);
    send_tick(0, 100);
    settle();
  endtask

  task automatic test_gain_extremes();
    set_side(LEFT, {JUNK, GAIN_MAX}, {JUNK, GAIN_MIN}, {JUNK, GAIN_MAX}, POS_MAX);
    set_side(RIGHT, GAIN_MIN, GAIN_MAX, GAIN_MIN, POS_MIN);
    send_tick(POS_MIN, POS_MAX);
    send_tick(POS_MAX, POS_MIN);
    send_tick(0, 0);
    send_tick(-1, 1);
    settle();
  endtask

  task automatic test_derivative();
    set_side(LEFT, 0, 0, GAIN_ONE, 0);
    set_side(RIGHT, 2, 0, -3, 0);
    send_tick(0, 7);
    send_tick(-5, -20);
    send_tick(-5, 1);
    send_tick(3, 0);
    settle();
  endtask

  // Drive both integrals into opposite rails, then walk them back by a known
  // amount so the saturated value shows up unclamped on the drive.
  task automatic test_integral_windup();
    set_side(LEFT, 0, 1, 0, POS_MAX);
    set_side(RIGHT, 0, 1, 0, POS_MIN);
    repeat (160) send_tick(POS_MIN, POS_MAX);
    settle();
    write_reg(REG_LEFT_TARGET, POS_MIN);
    write_reg(REG_RIGHT_TARGET, POS_MAX);
    repeat (128) send_tick(POS_MAX, POS_MIN);
    repeat (160) send_tick(POS_MAX, POS_MIN);
    settle();
    write_reg(REG_LEFT_TARGET, POS_MAX);
    write_reg(REG_RIGHT_TARGET, POS_MIN);
    repeat (128) send_tick(POS_MIN, POS_MAX);
    settle();
  endtask

  task automatic test_random_tuning();
    for (int ph = 0; ph < 8; ph++) begin
      steady = (ph == 3);
      for (int s = 0; s < 2; s++) begin
        set_side(s, rand_gain(), ($urandom_range(0, 1) ? rand_gain() : '0),
                 rand_gain(), rand_target());
      end
      repeat (48) send_tick(rand_position(target_pos[LEFT]), rand_position(target_pos[RIGHT]));
      settle();
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int s = 0; s < 2; s++) begin
      kp_gain[s]    = '0;
      ki_gain[s]    = '0;
      kd_gain[s]    = '0;
      target_pos[s] = '0;
      prev_error[s] = 0;
      error_sum[s]  = 0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_clamp_edges();
    test_gain_extremes();
    test_derivative();
    test_integral_windup();
    test_random_tuning();

    $display("%0d control ticks sent, %0d results checked, %0d register writes",
             ticks_sent, results_checked, reg_writes);
    $display("drive saturated on %0d left and %0d right results", left_clamps, right_clamps);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/dcpid_pkg.sv
src/dcpid_side.sv
src/dual_channel_pid_position_controller.sv
tb/sv/tb_top.sv
